>>> rtl/core/npcs_pkg.sv
// Package for the nearest palette color search block.
// Shared constants, command and register codes, and the pipeline tag type.
// No dependencies.
`default_nettype none

package npcs_pkg;

  localparam int IDX_W              = 8;
  localparam int DEF_PALETTE_DEPTH  = 256;
  localparam int DEF_COMPONENT_BITS = 6;

  // Distance weights per component.
  localparam int W_RED   = 39;
  localparam int W_GREEN = 51;
  localparam int W_BLUE  = 10;

  // Worst distance is 100 * 255^2 at 8-bit components, well under 2^24;
  // the start value 255^3 also fits.
  localparam int DIST_W = 24;
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(255 * 255 * 255);

  localparam logic [IDX_W-1:0] SEARCH_FIRST_RST = IDX_W'(10);
  localparam logic [IDX_W-1:0] SEARCH_LAST_RST  = IDX_W'(245);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic CFG_SEARCH_FIRST = 1'b0;
  localparam logic CFG_SEARCH_LAST  = 1'b1;

  // Tag that travels alongside each palette entry through the distance pipe.
  // written is clear for an entry that was never loaded.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             written;
    logic [IDX_W-1:0] idx;
  } tag_t;

endpackage

`default_nettype wire

>>> rtl/core/npcs_dist.sv
// Pipelined weighted squared distance unit, one palette entry per cycle.
// Stages: abs diff, square, weight, sum. Depends on npcs_pkg.
`default_nettype none

module npcs_dist #(
  parameter int COMPONENT_BITS = npcs_pkg::DEF_COMPONENT_BITS
) (
  input  wire                            clk,
  input  wire                            rst,
  input  npcs_pkg::tag_t                 tag_in,
  input  wire [3*COMPONENT_BITS-1:0]     entry,
  input  wire [COMPONENT_BITS-1:0]       q_red,
  input  wire [COMPONENT_BITS-1:0]       q_green,
  input  wire [COMPONENT_BITS-1:0]       q_blue,
  output npcs_pkg::tag_t                 tag_out,
  output logic [npcs_pkg::DIST_W-1:0]    distance
);

  localparam int CB = COMPONENT_BITS;
  localparam int SW = 2 * COMPONENT_BITS;
  localparam int DW = npcs_pkg::DIST_W;

  logic [CB-1:0] e_red, e_green, e_blue;
  assign e_blue  = entry[CB-1:0];
  assign e_green = entry[2*CB-1:CB];
  assign e_red   = entry[3*CB-1:2*CB];

  npcs_pkg::tag_t t1, t2, t3;
  logic [CB-1:0] d_red, d_green, d_blue;
  logic [SW-1:0] s_red, s_green, s_blue;
  logic [DW-1:0] p_red, p_green, p_blue;

  logic [SW-1:0] dx_red, dx_green, dx_blue;
  assign dx_red   = SW'(d_red);
  assign dx_green = SW'(d_green);
  assign dx_blue  = SW'(d_blue);

  // only the tag valid bits are reset
  always_ff @(posedge clk) begin
    t1 <= '{valid: !rst && tag_in.valid, last: tag_in.last,
            written: tag_in.written, idx: tag_in.idx};
    d_red   <= (q_red   > e_red)   ? q_red   - e_red   : e_red   - q_red;
    d_green <= (q_green > e_green) ? q_green - e_green : e_green - q_green;
    d_blue  <= (q_blue  > e_blue)  ? q_blue  - e_blue  : e_blue  - q_blue;

    t2 <= '{valid: !rst && t1.valid, last: t1.last, written: t1.written, idx: t1.idx};
    s_red   <= dx_red * dx_red;
    s_green <= dx_green * dx_green;
    s_blue  <= dx_blue * dx_blue;

    t3 <= '{valid: !rst && t2.valid, last: t2.last, written: t2.written, idx: t2.idx};
    p_red   <= DW'(s_red)   * DW'(npcs_pkg::W_RED);
    p_green <= DW'(s_green) * DW'(npcs_pkg::W_GREEN);
    p_blue  <= DW'(s_blue)  * DW'(npcs_pkg::W_BLUE);

    tag_out  <= '{valid: !rst && t3.valid, last: t3.last, written: t3.written,
                  idx: t3.idx};
    distance <= p_red + p_green + p_blue;
  end

endmodule

`default_nettype wire

>>> rtl/core/nearest_palette_color_search.sv
// Top level of the nearest palette color search block.
// Holds the palette memory, the search sequencer and the best-match compare.
// Depends on npcs_pkg and npcs_dist.
`default_nettype none

// After reset the block runs a clearing pass that marks every palette entry
// unwritten; the input is not ready meanwhile. A write item (cmd = write)
// stores one RGB entry; indices at or above the palette depth are dropped.
// A query item (cmd = query) scans palette indices search_first..search_last
// (clipped to the depth) through one pipelined distance unit fed by the
// palette memory read port, one entry per cycle, and returns the lowest index
// with the smallest weighted squared distance 39*dr^2 + 51*dg^2 + 10*db^2.
// Entries never written are skipped; if none in range was written, or the
// range is empty, the answer is search_first. From transfer to result a
// query passes through the reads issued on the memory read port, the four
// distance stages, the compare and the result load; an empty range goes
// straight to the result load. While a query runs the input is not ready; a
// finished result waits in the output register and a new item can be taken
// meanwhile. Configuration may be written only while the block is idle.

module nearest_palette_color_search #(
  parameter int PALETTE_DEPTH  = npcs_pkg::DEF_PALETTE_DEPTH,
  parameter int COMPONENT_BITS = npcs_pkg::DEF_COMPONENT_BITS
) (
  input  wire                             clk,
  input  wire                             rst,
  // configuration write port
  input  wire                             cfg_write,
  input  wire  [0:0]                      cfg_index,
  input  wire  [npcs_pkg::IDX_W-1:0]      cfg_data,
  // input channel
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             cmd,
  input  wire  [npcs_pkg::IDX_W-1:0]      entry_index,
  input  wire  [COMPONENT_BITS-1:0]       red,
  input  wire  [COMPONENT_BITS-1:0]       green,
  input  wire  [COMPONENT_BITS-1:0]       blue,
  // result channel
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [npcs_pkg::IDX_W-1:0]      nearest_index
);

  localparam int IW      = npcs_pkg::IDX_W;
  localparam int DW      = npcs_pkg::DIST_W;
  localparam int CB      = COMPONENT_BITS;
  localparam int AW      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  // highest index reachable both by the index width and the palette depth
  localparam int MAX_IDX = (PALETTE_DEPTH < 2**IW) ? PALETTE_DEPTH - 1 : 2**IW - 1;

  typedef enum logic [2:0] {
    ST_CLEAR,  // marking every entry unwritten after reset
    ST_IDLE,
    ST_SCAN,   // issuing reads
    ST_WAIT,   // draining the distance pipe
    ST_HOLD    // best index ready, waiting for the output register
  } state_t;

  state_t state;

  logic [IW-1:0] search_first, search_last;
  logic [IW-1:0] last_eff;
  logic          range_empty;

  logic [AW-1:0] clr_addr;
  logic [IW-1:0] scan_t;
  logic [IW-1:0] best_idx;
  logic [DW-1:0] best_dist;
  logic [CB-1:0] q_red, q_green, q_blue;

  // entry word: written flag on top of {red, green, blue}
  logic [3*CB:0]   palette [PALETTE_DEPTH];
  logic [3*CB:0]   rd_word;
  logic            rd_valid;
  logic            rd_last;
  logic [IW-1:0]   rd_idx;
  npcs_pkg::tag_t  rd_tag;
  npcs_pkg::tag_t  dist_tag;
  logic [DW-1:0]   distance;

  logic in_xfer, wr_en, out_free;

  assign in_ready    = (state == ST_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign wr_en       = in_xfer && (cmd == npcs_pkg::CMD_WRITE)
                       && (int'(entry_index) < PALETTE_DEPTH);
  assign out_free    = !out_valid || out_ready;
  assign last_eff    = (int'(search_last) > MAX_IDX) ? IW'(MAX_IDX) : search_last;
  assign range_empty = (search_first > last_eff);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_first <= npcs_pkg::SEARCH_FIRST_RST;
      search_last  <= npcs_pkg::SEARCH_LAST_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        npcs_pkg::CFG_SEARCH_FIRST: search_first <= cfg_data;
        npcs_pkg::CFG_SEARCH_LAST:  search_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  // palette memory: one write port (clearing pass or item write),
  // one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      palette[clr_addr] <= '0;
    end else if (wr_en) begin
      palette[AW'(entry_index)] <= {1'b1, red, green, blue};
    end
  end

  always_ff @(posedge clk) begin
    rd_word <= palette[AW'(scan_t)];
    rd_idx  <= scan_t;
    rd_last <= (scan_t == last_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN);
    end
  end

  assign rd_tag = '{valid: rd_valid, last: rd_last, written: rd_word[3*CB], idx: rd_idx};

  npcs_dist #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .tag_in   (rd_tag),
    .entry    (rd_word[3*CB-1:0]),
    .q_red    (q_red),
    .q_green  (q_green),
    .q_blue   (q_blue),
    .tag_out  (dist_tag),
    .distance (distance)
  );

  // sequencer, best-match tracking and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(PALETTE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_xfer && (cmd == npcs_pkg::CMD_QUERY)) begin
            q_red     <= red;
            q_green   <= green;
            q_blue    <= blue;
            best_idx  <= search_first;
            best_dist <= npcs_pkg::DIST_START;
            scan_t    <= search_first;
            state     <= range_empty ? ST_HOLD : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_t == last_eff) begin
            state <= ST_WAIT;
          end else begin
            scan_t <= scan_t + 1'b1;
          end
        end
        ST_WAIT: ;
        ST_HOLD: begin
          if (out_free) begin
            nearest_index <= best_idx;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // strict less-than keeps the lowest index on ties; unwritten entries never win
      if (dist_tag.valid) begin
        if (dist_tag.written && (distance < best_dist)) begin
          best_dist <= distance;
          best_idx  <= dist_tag.idx;
        end
        if (dist_tag.last) begin
          state <= ST_HOLD;
        end
      end
    end
  end

  // entries leave the distance pipe only while a query is in flight
  a_tag_in_query: assert property (@(posedge clk) disable iff (rst)
    dist_tag.valid |-> (state == ST_SCAN || state == ST_WAIT))
    else $error("distance result outside a query");

  // issued index stays inside the clipped search range
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_t >= search_first && scan_t <= last_eff))
    else $error("scan index outside search range");

  // best distance never grows during a scan
  a_best_mono: assert property (@(posedge clk) disable iff (rst)
    dist_tag.valid |=> (best_dist <= $past(best_dist)))
    else $error("best distance increased");

  // answer is search_first or an index inside the range
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |->
      (best_idx == search_first || (best_idx > search_first && best_idx <= last_eff)))
    else $error("best index outside search range");

endmodule

`default_nettype wire
